FILE: rtl/core/pol_pkg.sv
`default_nettype none

package pol_pkg;

    // Defaults for the top-level parameters
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 8;

    // Fixed field widths
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    // Operation codes carried by kind
    localparam logic [KIND_W-1:0] KIND_INS_FIRST = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INS_LAST  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INS_AT    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEL_FIRST = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEL_LAST  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DEL_AT    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_DUMP      = 3'd6;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd3;

    // Commands broadcast along the cell chain
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_HOLD   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_ROTATE = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/core/pol_cell.sv
`default_nettype none

module pol_cell
    import pol_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int IDX_W      = 4,
    parameter int INDEX      = 0
)
(
    input  wire logic                  clk,
    input  wire logic [OP_W-1:0]       op,
    input  wire logic [IDX_W-1:0]      idx,
    input  wire logic [IDX_W-1:0]      tail,
    input  wire logic [DATA_WIDTH-1:0] value,
    input  wire logic [DATA_WIDTH-1:0] left_data,
    input  wire logic [DATA_WIDTH-1:0] right_data,
    input  wire logic [DATA_WIDTH-1:0] head_data,
    output logic      [DATA_WIDTH-1:0] data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            OP_INSERT:
            begin
                // open a gap at idx: cells above take their left neighbor
                if (MY_IDX == idx)
                    data_next = value;
                else if (MY_IDX > idx)
                    data_next = left_data;
            end
            OP_DELETE:
            begin
                // close the gap at idx
                if (MY_IDX >= idx)
                    data_next = right_data;
            end
            OP_ROTATE:
            begin
                // advance toward the head, wrapping the head into the tail
                if (MY_IDX == tail)
                    data_next = head_data;
                else
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/positional_ordered_list.sv
// Edits (insert/delete at first, last or a position): one registered result in the cycle after
// the transfer; a new command may follow in the very next cycle.
// Dump: busy while it streams, one element per cycle (head of the cell chain,
// which rotates once per element); an empty dump gives one result in the cycle after it.
// Reset clears the fill level and the control state; element cells hold no reset value.
// Results are strobed for one cycle; the receiver cannot stall them.
`default_nettype none

module positional_ordered_list
    import pol_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int POS_W     = $clog2(CAPACITY + 2)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [KIND_W-1:0]     kind,
    input  wire logic [DATA_WIDTH-1:0] value,
    input  wire logic [POS_W-1:0]      position,
    output logic                       strobe,
    output logic [STATUS_W-1:0]        status,
    output logic [CNT_W-1:0]           count,
    output logic [DATA_WIDTH-1:0]      element,
    output logic                       last
);

    localparam int IDX_W = $clog2(CAPACITY);
    // compare width that holds both a position and fill + 1
    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    // control state
    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    logic [CNT_W-1:0]      fill_reg;
    logic [CNT_W-1:0]      fill_next;
    logic [IDX_W-1:0]      ptr_reg;
    logic [IDX_W-1:0]      ptr_next;

    // result registers
    logic                  strobe_reg;
    logic                  strobe_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [DATA_WIDTH-1:0] element_reg;
    logic [DATA_WIDTH-1:0] element_next;
    logic                  last_reg;
    logic                  last_next;

    // chain command, broadcast to every cell
    logic [OP_W-1:0]       op;
    logic [IDX_W-1:0]      op_idx;
    logic [IDX_W-1:0]      tail;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

    logic                  take;
    logic                  full;
    logic                  empty;
    logic [CMP_W-1:0]      pos_x;
    logic [CMP_W-1:0]      fill_x;
    logic [CMP_W-1:0]      pos_m1;
    logic [CNT_W-1:0]      fill_m1;
    logic                  dump_end;

    assign take    = start && (state_reg == S_IDLE);
    assign full    = (fill_reg == CNT_W'(CAPACITY));
    assign empty   = (fill_reg == '0);
    assign pos_x   = CMP_W'(position);
    assign fill_x  = CMP_W'(fill_reg);
    assign pos_m1  = pos_x - CMP_W'(1);
    assign fill_m1 = fill_reg - CNT_W'(1);
    assign tail    = fill_m1[IDX_W-1:0];
    assign dump_end = (ptr_reg == tail);

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        ptr_next     = ptr_reg;
        strobe_next  = 1'b0;
        status_next  = status_reg;
        count_next   = count_reg;
        element_next = element_reg;
        last_next    = last_reg;
        op           = OP_HOLD;
        op_idx       = '0;

        if (state_reg == S_DUMP)
        begin
            // stream the head and rotate the occupied cells by one
            op           = OP_ROTATE;
            strobe_next  = 1'b1;
            status_next  = STAT_OK;
            count_next   = fill_reg;
            element_next = cell_data[0];
            last_next    = dump_end;
            ptr_next     = ptr_reg + IDX_W'(1);
            if (dump_end)
                state_next = S_IDLE;
        end
        else if (take)
        begin
            strobe_next  = 1'b1;
            status_next  = STAT_OK;
            element_next = '0;
            last_next    = 1'b1;
            case (kind)
                KIND_INS_FIRST, KIND_INS_LAST, KIND_INS_AT:
                begin
                    if (full)
                        status_next = STAT_FULL;
                    else if ((kind == KIND_INS_AT) &&
                             ((pos_x == '0) || (pos_x > fill_x + CMP_W'(1))))
                        status_next = STAT_BADPOS;
                    else
                    begin
                        op = OP_INSERT;
                        if (kind == KIND_INS_FIRST)
                            op_idx = '0;
                        else if (kind == KIND_INS_LAST)
                            op_idx = fill_reg[IDX_W-1:0];
                        else
                            op_idx = pos_m1[IDX_W-1:0];
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                KIND_DEL_FIRST, KIND_DEL_LAST, KIND_DEL_AT:
                begin
                    if (empty)
                        status_next = STAT_EMPTY;
                    else if ((kind == KIND_DEL_AT) &&
                             ((pos_x == '0) || (pos_x > fill_x)))
                        status_next = STAT_BADPOS;
                    else
                    begin
                        op = OP_DELETE;
                        if (kind == KIND_DEL_FIRST)
                            op_idx = '0;
                        else if (kind == KIND_DEL_LAST)
                            op_idx = tail;
                        else
                            op_idx = pos_m1[IDX_W-1:0];
                        fill_next = fill_m1;
                    end
                end
                KIND_DUMP:
                begin
                    if (empty)
                        status_next = STAT_EMPTY;
                    else
                    begin
                        // results come from the dump cycles instead
                        strobe_next = 1'b0;
                        ptr_next    = '0;
                        state_next  = S_DUMP;
                    end
                end
                default:
                begin
                    // unused code: drop the command
                    strobe_next = 1'b0;
                end
            endcase
            count_next = fill_next;
        end
    end

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_head
            assign left_d = value;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_end
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        pol_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .op         (op),
            .idx        (op_idx),
            .tail       (tail),
            .value      (value),
            .left_data  (left_d),
            .right_data (right_d),
            .head_data  (cell_data[0]),
            .data       (cell_data[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            ptr_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            ptr_reg    <= ptr_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        count_reg   <= count_next;
        element_reg <= element_next;
        last_reg    <= last_next;
    end

    assign busy    = (state_reg == S_DUMP);
    assign strobe  = strobe_reg;
    assign status  = status_reg;
    assign count   = count_reg;
    assign element = element_reg;
    assign last    = last_reg;

endmodule

`default_nettype wire

FILE: tb/positional_ordered_list_tb.sv
`default_nettype none

module positional_ordered_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pol_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int DATA_WIDTH  = DATA_WIDTH_DEF;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int POS_W       = $clog2(CAPACITY + 2);
    localparam int HALF_PERIOD = 2;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 425;
    // The slowest legal run stays well under this limit: full-list dumps plus long gaps.
    localparam int CYCLE_LIMIT  = 300000;
    // Kind 7 has no meaning; the block must swallow it without a result.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [CNT_W-1:0]      count;
        logic [DATA_WIDTH-1:0] element;
        logic                  last;
    } list_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [KIND_W-1:0]     kind;
    logic [DATA_WIDTH-1:0] value;
    logic [POS_W-1:0]      position;
    logic                  strobe;
    logic [STATUS_W-1:0]   status;
    logic [CNT_W-1:0]      count;
    logic [DATA_WIDTH-1:0] element;
    logic                  last;

    // Shadow copy of the list contents, first element at index 0
    logic [DATA_WIDTH-1:0] shadow_list[$];
    // Results still owed by the block, oldest first
    list_result_t          due_results[$];

    int fail_count;
    int cycle_count;
    int ops_done;
    int dumps_done;
    int full_rejects;
    int empty_rejects;
    int position_rejects;
    int ignored_ops;
    int results_checked;
    int peak_fill;

    positional_ordered_list #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .kind     (kind),
        .value    (value),
        .position (position),
        .strobe   (strobe),
        .status   (status),
        .count    (count),
        .element  (element),
        .last     (last)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Watchdog: abort the run if the block hangs or stops answering.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Queue one expected result carrying the current list length.
    function automatic void owe_result(logic [STATUS_W-1:0] st,
                                       logic [DATA_WIDTH-1:0] elem, logic fin);
        list_result_t r;
        r.status  = st;
        r.count   = CNT_W'(shadow_list.size());
        r.element = elem;
        r.last    = fin;
        due_results.push_back(r);
    endfunction

    // Apply one accepted operation to the shadow list and queue what it yields.
    function automatic void apply_list_op(logic [KIND_W-1:0] op,
                                          logic [DATA_WIDTH-1:0] v,
                                          logic [POS_W-1:0] p);
        logic [STATUS_W-1:0] st;
        int                  fill;
        int                  slot;
        fill = shadow_list.size();
        st   = STAT_OK;
        slot = 0;
        ops_done++;
        case (op)
            KIND_INS_FIRST, KIND_INS_LAST, KIND_INS_AT:
            begin
                // Fullness wins over a bad position
                if (fill >= CAPACITY)
                    st = STAT_FULL;
                else if (op == KIND_INS_FIRST)
                    slot = 0;
                else if (op == KIND_INS_LAST)
                    slot = fill;
                else if (p < 1 || int'(p) > fill + 1)
                    st = STAT_BADPOS;
                else
                    slot = int'(p) - 1;
                if (st == STAT_OK)
                    shadow_list.insert(slot, v);
            end
            KIND_DEL_FIRST, KIND_DEL_LAST, KIND_DEL_AT:
            begin
                // Emptiness wins over a bad position; count+1 is out of range
                if (fill == 0)
                    st = STAT_EMPTY;
                else if (op == KIND_DEL_FIRST)
                    slot = 0;
                else if (op == KIND_DEL_LAST)
                    slot = fill - 1;
                else if (p < 1 || int'(p) > fill)
                    st = STAT_BADPOS;
                else
                    slot = int'(p) - 1;
                if (st == STAT_OK)
                    shadow_list.delete(slot);
            end
            KIND_DUMP:
            begin
                dumps_done++;
                if (fill == 0)
                    owe_result(STAT_EMPTY, '0, 1'b1);
                for (int i = 0; i < fill; i++)
                    owe_result(STAT_OK, shadow_list[i], i == fill - 1);
                return;
            end
            default:
            begin
                ops_done--;
                ignored_ops++;
                return;
            end
        endcase
        if (st == STAT_FULL)   full_rejects++;
        if (st == STAT_EMPTY)  empty_rejects++;
        if (st == STAT_BADPOS) position_rejects++;
        if (shadow_list.size() > peak_fill)
            peak_fill = shadow_list.size();
        owe_result(st, '0, 1'b1);
    endfunction

    // Result checker: every strobed result must match the oldest one owed.
    always @(posedge clk)
    begin : check_results
        list_result_t want;
        if (rst_n && strobe)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected result: status %0d count %0d element %0h last %0b",
                       status, count, element, last);
                fail_count++;
            end
            else
            begin
                want = due_results.pop_front();
                results_checked++;
                if (status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, status);
                    fail_count++;
                end
                if (count !== want.count)
                begin
                    $error("count mismatch: expected %0d, actual %0d", want.count, count);
                    fail_count++;
                end
                if (element !== want.element)
                begin
                    $error("element mismatch: expected %0h, actual %0h",
                           want.element, element);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last mismatch: expected %0b, actual %0b", want.last, last);
                    fail_count++;
                end
            end
        end
    end

    // Present one command and hold it until the block takes it. Start stays
    // high on return so a following command can ride the next edge; the gap
    // task is what drops it.
    task automatic send_op(input logic [KIND_W-1:0] op, input logic [DATA_WIDTH-1:0] v,
                           input logic [POS_W-1:0] p);
        start    <= 1'b1;
        kind     <= op;
        value    <= v;
        position <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_list_op(op, v, p);
    endtask

    // Drop start and idle for the given number of cycles; zero keeps start up.
    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // Random position: usually inside the legal window, otherwise anywhere.
    function automatic logic [POS_W-1:0] pick_position(logic is_insert);
        int fill;
        fill = shadow_list.size();
        if ($urandom_range(99) < 85)
        begin
            if (is_insert)
                return POS_W'($urandom_range(fill + 1, 1));
            return POS_W'($urandom_range(fill > 0 ? fill : 1, 1));
        end
        return POS_W'($urandom_range(CAPACITY + 1, 0));
    endfunction

    // Empty-list corners, sole-element removal, position bounds, unused kind.
    task automatic test_directed_edges();
        send_op(KIND_DUMP,      8'h00, 5'd0);   idle_gap(pick_gap());
        send_op(KIND_DEL_FIRST, 8'h00, 5'd0);   idle_gap(pick_gap());
        send_op(KIND_DEL_LAST,  8'h00, 5'd0);   idle_gap(pick_gap());
        send_op(KIND_DEL_AT,    8'h00, 5'd0);   idle_gap(pick_gap());
        send_op(KIND_INS_AT,    8'h33, 5'd0);   idle_gap(pick_gap());
        send_op(KIND_INS_AT,    8'h33, 5'd2);   idle_gap(pick_gap());
        send_op(KIND_INS_AT,    8'hFF, 5'd1);   idle_gap(pick_gap());
        send_op(KIND_DEL_AT,    8'h00, 5'd2);   idle_gap(pick_gap());
        // remove the sole element through each delete flavor
        send_op(KIND_DEL_AT,    8'h00, 5'd1);   idle_gap(pick_gap());
        send_op(KIND_INS_LAST,  8'h00, 5'd0);   idle_gap(pick_gap());
        send_op(KIND_DEL_LAST,  8'h00, 5'd0);   idle_gap(pick_gap());
        send_op(KIND_INS_FIRST, 8'hA5, 5'd0);   idle_gap(pick_gap());
        send_op(KIND_DEL_FIRST, 8'h00, 5'd0);   idle_gap(pick_gap());
        // build a short list with a middle and a tail insert
        send_op(KIND_INS_FIRST, 8'h5A, 5'd0);   idle_gap(pick_gap());
        send_op(KIND_INS_LAST,  8'hC3, 5'd0);   idle_gap(pick_gap());
        send_op(KIND_INS_AT,    8'h81, 5'd2);   idle_gap(pick_gap());
        send_op(KIND_INS_AT,    8'h7E, 5'd4);   idle_gap(pick_gap());
        send_op(KIND_DUMP,      8'h00, 5'd0);   idle_gap(pick_gap());
        send_op(KIND_DEL_AT,    8'h00, 5'd2);   idle_gap(pick_gap());
        send_op(KIND_UNUSED,    8'hFF, 5'd17);  idle_gap(pick_gap());
        send_op(KIND_DUMP,      8'h00, 5'd0);
        idle_gap($urandom_range(4, 1));
    endtask

    // Fill to capacity, hit every full and count+1 rejection, dump a full list.
    task automatic test_capacity_limits();
        logic [KIND_W-1:0] op;
        while (shadow_list.size() < CAPACITY)
        begin
            op = KIND_W'($urandom_range(2, 0));
            send_op(op, DATA_WIDTH'($urandom), pick_position(1'b1));
        end
        // back-to-back against the full list
        send_op(KIND_INS_FIRST, 8'h11, 5'd0);
        send_op(KIND_INS_LAST,  8'h22, 5'd0);
        send_op(KIND_INS_AT,    8'h44, 5'd0);
        send_op(KIND_INS_AT,    8'h88, 5'd17);
        send_op(KIND_DUMP,      8'h00, 5'd0);
        send_op(KIND_DEL_AT,    8'h00, 5'd0);
        send_op(KIND_DEL_AT,    8'h00, 5'd17);
        send_op(KIND_DEL_AT,    8'h00, 5'd16);
        send_op(KIND_DEL_AT,    8'h00, 5'd16);
        send_op(KIND_DUMP,      8'h00, 5'd0);
        idle_gap($urandom_range(4, 1));
    endtask

    // Random traffic that drifts between growing, shrinking and balanced
    // phases so the list length sweeps empty to full and back many times.
    task automatic test_random_mix(input int item_target);
        int                    sent;
        int                    grow_pct;
        int                    r;
        logic                  burst;
        logic [KIND_W-1:0]     op;
        logic [DATA_WIDTH-1:0] v;
        logic [POS_W-1:0]      p;
        sent     = 0;
        grow_pct = 85;
        burst    = 1'b0;
        while (sent < item_target)
        begin
            if (sent % 30 == 0)
            begin
                r        = $urandom_range(2);
                grow_pct = (r == 0) ? 85 : (r == 1) ? 15 : 50;
                burst    = ($urandom_range(3) == 0);
            end
            r = $urandom_range(99);
            if (r < 9)
                op = KIND_DUMP;
            else if (r < 11)
                op = KIND_UNUSED;
            else if ($urandom_range(99) < grow_pct)
                op = KIND_W'($urandom_range(2, 0));
            else
                op = KIND_W'($urandom_range(5, 3));
            v = DATA_WIDTH'($urandom);
            p = pick_position(op == KIND_INS_AT);
            send_op(op, v, p);
            if (op != KIND_UNUSED)
                sent++;
            if (!burst)
                idle_gap(pick_gap());
        end
        idle_gap(1);
    endtask

    initial
    begin
        fail_count       = 0;
        cycle_count      = 0;
        ops_done         = 0;
        dumps_done       = 0;
        full_rejects     = 0;
        empty_rejects    = 0;
        position_rejects = 0;
        ignored_ops      = 0;
        results_checked  = 0;
        peak_fill        = 0;
        rst_n    <= 1'b0;
        start    <= 1'b0;
        kind     <= KIND_INS_FIRST;
        value    <= '0;
        position <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_capacity_limits();
        test_random_mix(RANDOM_ITEMS);

        // Drain: wait for every owed result, then watch a while for strays.
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (2 * CAPACITY + 4) @(posedge clk);

        $display("ran %0d list operations: %0d dumps, %0d ignored commands, peak length %0d",
                 ops_done, dumps_done, ignored_ops, peak_fill);
        $display("checked %0d results: %0d full, %0d empty, %0d bad-position rejections",
                 results_checked, full_rejects, empty_rejects, position_rejects);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
